@@ rtl/bmf_pkg.sv @@
// ============================================================================
// bmf_pkg
// Shared types and constants of the box mean filter: request payloads,
// configuration register indexes and their reset values.
// ============================================================================
`default_nettype none

package bmf_pkg;

    localparam int PIXEL_W     = 8;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 11;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_WINDOW_SIZE  = 2'd2
    } cfg_index_t;

    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_WIDTH  = 11'd640;
    localparam logic [CFG_DATA_W-1:0] RESET_IMAGE_HEIGHT = 11'd480;
    localparam logic [3:0]            RESET_WINDOW_SIZE  = 4'd5;

    typedef struct packed {
        logic [PIXEL_W-1:0] blue_in;
        logic [PIXEL_W-1:0] green_in;
        logic [PIXEL_W-1:0] red_in;
        logic               flush;
    } bmf_in_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] blue_out;
        logic [PIXEL_W-1:0] green_out;
        logic [PIXEL_W-1:0] red_out;
        logic               frame_last;
    } bmf_out_t;

endpackage

`default_nettype wire

@@ rtl/bmf_divider.sv @@
// ============================================================================
// bmf_divider
// Three-channel restoring divider: one quotient bit per cycle.
// The quotient is known to fit in one pixel.
// ============================================================================
`default_nettype none

module bmf_divider #(
    parameter int SUM_W = 16,
    parameter int DIV_W = 8
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  start,
    input  wire logic [2:0][SUM_W-1:0]                 dividend,
    input  wire logic [DIV_W-1:0]                      divisor,
    output logic                                       done,
    output logic [2:0][bmf_pkg::PIXEL_W-1:0]           quotient
);

    localparam int STEPS  = bmf_pkg::PIXEL_W;
    localparam int STEP_W = $clog2(STEPS);
    localparam int CMP_W  = DIV_W + STEPS;

    logic [2:0][CMP_W-1:0]            rem_reg;
    logic [2:0][CMP_W-1:0]            rem_next;
    logic [CMP_W-1:0]                 dvs_reg;
    logic [2:0][bmf_pkg::PIXEL_W-1:0] quot_reg;
    logic [2:0]                       bit_next;
    logic [STEP_W-1:0]                step_reg;
    logic                             busy_reg;
    logic                             done_reg;

    // compare and subtract the shifted divisor on every channel
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            if (rem_reg[ch] >= dvs_reg) begin
                rem_next[ch] = rem_reg[ch] - dvs_reg;
                bit_next[ch] = 1'b1;
            end else begin
                rem_next[ch] = rem_reg[ch];
                bit_next[ch] = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= !start && busy_reg && (step_reg == STEP_W'(STEPS - 1));
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end else if (busy_reg) begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(STEPS - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            for (int ch = 0; ch < 3; ch++) begin
                rem_reg[ch] <= CMP_W'(dividend[ch]);
            end
            dvs_reg <= CMP_W'(divisor) << (STEPS - 1);
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            dvs_reg <= dvs_reg >> 1;
            for (int ch = 0; ch < 3; ch++) begin
                quot_reg[ch] <= {quot_reg[ch][bmf_pkg::PIXEL_W-2:0], bit_next[ch]};
            end
        end
    end

    assign done     = done_reg;
    assign quotient = quot_reg;

endmodule

`default_nettype wire

@@ rtl/box_mean_filter_rgb_unit.sv @@
// ============================================================================
// box_mean_filter_rgb_unit
// Box mean filter over a raster stream of 8-bit BGR pixels.
// ============================================================================
// Usage:
//  - s_ channel: one pixel request per item (flush = 1 carries no pixel and
//    only pushes out pending results). m_ channel: filtered or passed-through
//    pixel, frame_last marks the final result of a frame.
//  - cfg_ channel: register writes (index 0 width, 1 height, 2 window size),
//    always ready. Sizes are latched when the first pixel of a frame arrives.
//  - Results trail the pixels by half a window in rows and in columns; after
//    the last pixel, flush requests drain the tail of the frame.
//  - One request is worked on at a time. A pixel passes S_READ and S_UPDATE;
//    a pass-through result adds S_PTRD and S_RESULT, a filtered result
//    S_DIV (until the divider is done) and S_RESULT. A drain result passes
//    S_PTRD and S_RESULT; the first pixel of a frame adds S_SETUP. Row store
//    and column sums are single-port-write synchronous memories; the column
//    sums are read in S_READ and written back in S_UPDATE.
//  - Reset (aresetn low, synchronous) closes any open frame, clears the
//    counters and restores the register defaults 640 x 480, window 5. The
//    memories are not cleared: each entry is written before it is used.
//  - A result waits in the output register while m_ready is low; the next
//    request is still accepted and held until the register frees up.
// ============================================================================
`default_nettype none

module box_mean_filter_rgb_unit #(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024,
    parameter int MAX_WINDOW = 15
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    // pixel requests
    input  wire logic                                 s_valid,
    output logic                                      s_ready,
    input  wire bmf_pkg::bmf_in_t                     s_data,
    // results
    output logic                                      m_valid,
    input  wire logic                                 m_ready,
    output bmf_pkg::bmf_out_t                         m_data,
    // register writes
    input  wire logic                                 cfg_valid,
    output logic                                      cfg_ready,
    input  wire logic [bmf_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  wire logic [bmf_pkg::CFG_DATA_W-1:0]       cfg_data
);

    localparam int PIX_MAX  = 2**bmf_pkg::PIXEL_W - 1;
    localparam int COL_W    = $clog2(MAX_WIDTH);
    localparam int ROW_W    = $clog2(MAX_HEIGHT);
    localparam int FW_W     = $clog2(MAX_WIDTH + 1);
    localparam int FH_W     = $clog2(MAX_HEIGHT + 1);
    localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
    localparam int RING_W   = $clog2(MAX_WINDOW + 1);   // ring holds at least MAX_WINDOW + 1 rows
    localparam int TAP_W    = $clog2(MAX_WINDOW);
    localparam int CNT_W    = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);
    localparam int DSQ_W    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);
    localparam int CS_W     = $clog2(MAX_WINDOW * PIX_MAX + 1);
    localparam int WS_W     = $clog2(MAX_WINDOW * MAX_WINDOW * PIX_MAX + 1);
    localparam int RS_DEPTH = 2**(RING_W + COL_W);
    localparam int CS_DEPTH = 2**COL_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_READ,
        S_UPDATE,
        S_PTRD,
        S_DIV,
        S_RESULT
    } state_t;

    typedef logic [2:0][bmf_pkg::PIXEL_W-1:0] pixel_t;
    typedef logic [2:0][CS_W-1:0]             col_sum_t;
    typedef logic [2:0][WS_W-1:0]             win_sum_t;

    state_t                         state_reg;

    // register file and per-frame latched sizes
    logic [bmf_pkg::CFG_DATA_W-1:0] cfg_width_reg;
    logic [bmf_pkg::CFG_DATA_W-1:0] cfg_height_reg;
    logic [3:0]                     cfg_window_reg;
    logic [FW_W-1:0]                fw_reg;
    logic [FH_W-1:0]                fh_reg;
    logic [WIN_W-1:0]               fwin_reg;
    logic [WIN_W-1:0]               half_reg;
    logic [DSQ_W-1:0]               dsq_reg;
    logic [CNT_W-1:0]               total_reg;
    logic [CNT_W-1:0]               lag_reg;

    // frame progress
    logic                           frame_open_reg;
    logic                           inputs_done_reg;
    logic [COL_W-1:0]               in_col_reg;
    logic [ROW_W-1:0]               in_row_reg;
    logic [RING_W-1:0]              in_ring_reg;
    logic [CNT_W-1:0]               in_idx_reg;
    logic [COL_W-1:0]               out_col_reg;
    logic [RING_W-1:0]              out_ring_reg;
    logic [CNT_W-1:0]               out_cnt_reg;

    // datapath
    pixel_t                         pix_reg;
    logic                           interior_reg;
    win_sum_t                       ws_reg;
    col_sum_t                       tap_reg [MAX_WINDOW];
    logic                           m_valid_reg;
    bmf_pkg::bmf_out_t              m_data_reg;

    // memories
    pixel_t                         row_mem [RS_DEPTH];
    pixel_t                         rs_rdata_reg;
    col_sum_t                       col_mem [CS_DEPTH];
    col_sum_t                       cs_rdata_reg;

    logic                           rs_we;
    logic                           rs_re;
    logic [RING_W+COL_W-1:0]        rs_waddr;
    logic [RING_W+COL_W-1:0]        rs_raddr;
    logic [RING_W-1:0]              old_ring;

    // latch values derived from the registers
    logic [31:0]                    width_val;
    logic [31:0]                    height_val;
    logic [31:0]                    win_val;
    logic [FW_W-1:0]                fw_latch;
    logic [FH_W-1:0]                fh_latch;
    logic [WIN_W-1:0]               fwin_latch;

    // per-pixel decisions
    logic                           row_first;
    logic                           row_ge_win;
    logic                           col_first;
    logic                           col_ge_win;
    logic                           emit_now;
    logic                           interior_now;
    logic                           last_in;
    logic                           last_out;
    logic                           col_wrap;
    logic                           out_col_wrap;
    col_sum_t                       tap_sel;
    col_sum_t                       cs_next;
    win_sum_t                       ws_next;

    logic                           div_start;
    logic                           div_done;
    pixel_t                         div_q;

    // ------------------------------------------------------------------
    // Register clamping: zero counts as one, oversize saturates, an even
    // window drops to the next odd size.
    // ------------------------------------------------------------------
    always_comb begin
        width_val = 32'(cfg_width_reg);
        if (width_val == 32'd0) begin
            width_val = 32'd1;
        end else if (width_val > 32'(MAX_WIDTH)) begin
            width_val = 32'(MAX_WIDTH);
        end

        height_val = 32'(cfg_height_reg);
        if (height_val == 32'd0) begin
            height_val = 32'd1;
        end else if (height_val > 32'(MAX_HEIGHT)) begin
            height_val = 32'(MAX_HEIGHT);
        end

        win_val = 32'(cfg_window_reg);
        if (win_val > 32'(MAX_WINDOW)) begin
            win_val = 32'(MAX_WINDOW);
        end
        if (!win_val[0]) begin
            win_val = (win_val == 32'd0) ? 32'd1 : win_val - 32'd1;
        end

        fw_latch   = FW_W'(width_val);
        fh_latch   = FH_W'(height_val);
        fwin_latch = WIN_W'(win_val);
    end

    // ------------------------------------------------------------------
    // Column sums and running window sums. A column sum covers the last
    // window rows; row zero of a frame overwrites instead of adding, so the
    // store needs no clearing. The window sum restarts at each row start and
    // drops the column that slides out of the window.
    // ------------------------------------------------------------------
    assign row_first  = (in_row_reg == '0);
    assign row_ge_win = 32'(in_row_reg) >= 32'(fwin_reg);
    assign col_first  = (in_col_reg == '0);
    assign col_ge_win = 32'(in_col_reg) >= 32'(fwin_reg);
    assign tap_sel    = tap_reg[TAP_W'(fwin_reg - WIN_W'(1))];

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            cs_next[ch] = (row_first ? CS_W'(0) : cs_rdata_reg[ch])
                        + CS_W'(pix_reg[ch])
                        - (row_ge_win ? CS_W'(rs_rdata_reg[ch]) : CS_W'(0));
            if (col_first) begin
                ws_next[ch] = WS_W'(cs_next[ch]);
            end else begin
                ws_next[ch] = ws_reg[ch] + WS_W'(cs_next[ch])
                            - (col_ge_win ? WS_W'(tap_sel[ch]) : WS_W'(0));
            end
        end
    end

    // the pixel just stored is the bottom-right corner of the result's window
    assign emit_now     = (in_idx_reg >= lag_reg);
    assign interior_now = (32'(in_row_reg) + 32'd1 >= 32'(fwin_reg)) &&
                          (32'(in_col_reg) + 32'd1 >= 32'(fwin_reg));
    assign last_in      = ((in_idx_reg + CNT_W'(1)) == total_reg);
    assign last_out     = ((out_cnt_reg + CNT_W'(1)) == total_reg);
    assign col_wrap     = ((FW_W'(in_col_reg) + FW_W'(1)) == fw_reg);
    assign out_col_wrap = ((FW_W'(out_col_reg) + FW_W'(1)) == fw_reg);
    assign div_start    = (state_reg == S_UPDATE) && emit_now && interior_now;

    // ------------------------------------------------------------------
    // Row store: ring of pixel rows. The current pixel is written while the
    // pixel one window up leaves through the read port; a second read
    // fetches the pass-through pixel once the write has landed.
    // ------------------------------------------------------------------
    assign old_ring = in_ring_reg - RING_W'(fwin_reg);
    assign rs_we    = (state_reg == S_READ);
    assign rs_re    = (state_reg == S_READ) || (state_reg == S_PTRD);
    assign rs_waddr = {in_ring_reg, in_col_reg};
    assign rs_raddr = (state_reg == S_READ) ? {old_ring, in_col_reg}
                                            : {out_ring_reg, out_col_reg};

    always_ff @(posedge aclk) begin
        if (rs_we) begin
            row_mem[rs_waddr] <= pix_reg;
        end
        if (rs_re) begin
            rs_rdata_reg <= row_mem[rs_raddr];
        end
    end

    // column sums: read in S_READ, written back in S_UPDATE
    always_ff @(posedge aclk) begin
        if (state_reg == S_UPDATE) begin
            col_mem[in_col_reg] <= cs_next;
        end
        if (state_reg == S_READ) begin
            cs_rdata_reg <= col_mem[in_col_reg];
        end
    end

    bmf_divider #(
        .SUM_W (WS_W),
        .DIV_W (DSQ_W)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (ws_next),
        .divisor  (dsq_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    // ------------------------------------------------------------------
    // Sequencer, register file and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            cfg_width_reg   <= bmf_pkg::RESET_IMAGE_WIDTH;
            cfg_height_reg  <= bmf_pkg::RESET_IMAGE_HEIGHT;
            cfg_window_reg  <= bmf_pkg::RESET_WINDOW_SIZE;
            frame_open_reg  <= 1'b0;
            inputs_done_reg <= 1'b0;
            in_col_reg      <= '0;
            in_row_reg      <= '0;
            in_ring_reg     <= '0;
            in_idx_reg      <= '0;
            out_col_reg     <= '0;
            out_ring_reg    <= '0;
            out_cnt_reg     <= '0;
            m_valid_reg     <= 1'b0;
        end else begin
            // drop the result once taken; in S_RESULT the load below decides
            if (m_valid_reg && m_ready && (state_reg != S_RESULT)) begin
                m_valid_reg <= 1'b0;
            end

            if (cfg_valid) begin
                case (cfg_index)
                    bmf_pkg::CFG_IMAGE_WIDTH:  cfg_width_reg  <= cfg_data;
                    bmf_pkg::CFG_IMAGE_HEIGHT: cfg_height_reg <= cfg_data;
                    bmf_pkg::CFG_WINDOW_SIZE:  cfg_window_reg <= cfg_data[3:0];
                    default: ;
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        if (!frame_open_reg) begin
                            // first pixel opens the frame; a stray flush is dropped
                            if (!s_data.flush) begin
                                fw_reg         <= fw_latch;
                                fh_reg         <= fh_latch;
                                fwin_reg       <= fwin_latch;
                                half_reg       <= fwin_latch >> 1;
                                dsq_reg        <= DSQ_W'(fwin_latch) * DSQ_W'(fwin_latch);
                                frame_open_reg <= 1'b1;
                                pix_reg        <= {s_data.red_in, s_data.green_in,
                                                   s_data.blue_in};
                                state_reg      <= S_SETUP;
                            end
                        end else if (inputs_done_reg) begin
                            // drain: any request releases the next pending result
                            state_reg <= S_PTRD;
                        end else if (!s_data.flush) begin
                            pix_reg   <= {s_data.red_in, s_data.green_in, s_data.blue_in};
                            state_reg <= S_READ;
                        end
                    end
                end

                S_SETUP: begin
                    total_reg <= CNT_W'(fw_reg) * CNT_W'(fh_reg);
                    lag_reg   <= CNT_W'(half_reg) * CNT_W'(fw_reg) + CNT_W'(half_reg);
                    state_reg <= S_READ;
                end

                S_READ: begin
                    state_reg <= S_UPDATE;
                end

                S_UPDATE: begin
                    ws_reg     <= ws_next;
                    tap_reg[0] <= cs_next;
                    for (int k = 1; k < MAX_WINDOW; k++) begin
                        tap_reg[k] <= tap_reg[k-1];
                    end
                    interior_reg <= interior_now;

                    // advance the input position
                    in_idx_reg <= in_idx_reg + CNT_W'(1);
                    if (col_wrap) begin
                        in_col_reg  <= '0;
                        in_row_reg  <= in_row_reg + ROW_W'(1);
                        in_ring_reg <= in_ring_reg + RING_W'(1);
                    end else begin
                        in_col_reg <= in_col_reg + COL_W'(1);
                    end
                    if (last_in) begin
                        inputs_done_reg <= 1'b1;
                    end

                    if (!emit_now) begin
                        state_reg <= S_IDLE;
                    end else if (interior_now) begin
                        state_reg <= S_DIV;
                    end else begin
                        state_reg <= S_PTRD;
                    end
                end

                S_PTRD: begin
                    state_reg <= S_RESULT;
                end

                S_DIV: begin
                    if (div_done) begin
                        state_reg <= S_RESULT;
                    end
                end

                S_RESULT: begin
                    // hold until the output register is free
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg.blue_out   <= interior_reg ? div_q[0] : rs_rdata_reg[0];
                        m_data_reg.green_out  <= interior_reg ? div_q[1] : rs_rdata_reg[1];
                        m_data_reg.red_out    <= interior_reg ? div_q[2] : rs_rdata_reg[2];
                        m_data_reg.frame_last <= last_out;
                        if (last_out) begin
                            // close the frame
                            frame_open_reg  <= 1'b0;
                            inputs_done_reg <= 1'b0;
                            in_col_reg      <= '0;
                            in_row_reg      <= '0;
                            in_ring_reg     <= '0;
                            in_idx_reg      <= '0;
                            out_col_reg     <= '0;
                            out_ring_reg    <= '0;
                            out_cnt_reg     <= '0;
                        end else begin
                            out_cnt_reg <= out_cnt_reg + CNT_W'(1);
                            if (out_col_wrap) begin
                                out_col_reg  <= '0;
                                out_ring_reg <= out_ring_reg + RING_W'(1);
                            end else begin
                                out_col_reg <= out_col_reg + COL_W'(1);
                            end
                        end
                        interior_reg <= 1'b0;
                        state_reg    <= S_IDLE;
                    end
                end

                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;
    assign cfg_ready = 1'b1;

endmodule

`default_nettype wire
